// ===== rtl/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared constants and types for the DLE/ETX packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

	localparam int MAX_PACKET = 1024;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 10;
	localparam int LEN_W  = 11;
	localparam int SUM_W  = 16;

	localparam logic [BYTE_W-1:0] DLE_CODE = 8'h10;
	localparam logic [BYTE_W-1:0] ETX_CODE = 8'h03;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_END      = 2'd1,
		KIND_TOO_LONG = 2'd2,
		KIND_ABORT    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              result_kind;
		logic [BYTE_W-1:0]  data_byte;
		logic [POS_W-1:0]   byte_position;
		logic [LEN_W-1:0]   packet_length;
		logic               checksum_ok;
	} result_t;

endpackage

// ===== rtl/dpd_if.sv =====
// ----------------------------------------------------------------------------
// dpd_if
// Valid/ready channels of the deframer: raw bytes in, results out.
// ----------------------------------------------------------------------------
interface dpd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [dpd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpd_result_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 result_kind;
	logic [dpd_pkg::BYTE_W-1:0] data_byte;
	logic [dpd_pkg::POS_W-1:0]  byte_position;
	logic [dpd_pkg::LEN_W-1:0]  packet_length;
	logic                       checksum_ok;

	modport source (output valid, output result_kind, output data_byte,
		output byte_position, output packet_length, output checksum_ok,
		input ready);
	modport sink   (input valid, input result_kind, input data_byte,
		input byte_position, input packet_length, input checksum_ok,
		output ready);
endinterface

// ===== rtl/dpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// dpd_in_stage
// Input register: holds one received word until the framer consumes it.
// ----------------------------------------------------------------------------
module dpd_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	dpd_byte_if.sink                   rx,
	input  logic                       take,
	output logic                       valid_s1,
	output logic [dpd_pkg::BYTE_W-1:0] byte_s1
);

	// The register refills in the same cycle that its word is consumed.
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

// ===== rtl/dpd_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// dpd_frame_fsm
// Framing state machine: unstuffing, length limit, running checksum.
// ----------------------------------------------------------------------------
module dpd_frame_fsm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [dpd_pkg::BYTE_W-1:0] byte_s1,
	input  logic [dpd_pkg::LEN_W-1:0]  max_length,
	output logic                       res_valid,
	output dpd_pkg::result_t           res
);

	typedef enum logic [1:0] {
		MODE_HUNT    = 2'd0,
		MODE_WAIT_ID = 2'd1,
		MODE_DATA    = 2'd2,
		MODE_ESC     = 2'd3
	} mode_t;

	localparam logic [dpd_pkg::LEN_W-1:0] CAP = dpd_pkg::LEN_W'(dpd_pkg::MAX_PACKET);

	mode_t                      mode_q, mode_d;
	logic [dpd_pkg::LEN_W-1:0]  count_q, count_d, base_count, limit;
	logic [dpd_pkg::SUM_W-1:0]  sum_two_q, sum_two_d;
	logic [dpd_pkg::SUM_W-1:0]  sum_one_q, sum_one_d, base_one;
	logic [dpd_pkg::SUM_W-1:0]  sum_cur_q, sum_cur_d, base_cur;
	logic [dpd_pkg::BYTE_W-1:0] last_q, last_d, base_last;
	logic [dpd_pkg::BYTE_W-1:0] prior_q, prior_d;
	logic                       do_store;
	logic [dpd_pkg::SUM_W-1:0]  tail;

	assign limit = (max_length > CAP) ? CAP : max_length;
	assign tail  = {prior_q, last_q};

	// An ID byte starts a fresh packet, so the store path sees cleared state.
	always_comb begin
		if (mode_q == MODE_WAIT_ID) begin
			base_count = '0;
			base_one   = '0;
			base_cur   = '0;
			base_last  = '0;
		end else begin
			base_count = count_q;
			base_one   = sum_one_q;
			base_cur   = sum_cur_q;
			base_last  = last_q;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		count_d   = count_q;
		sum_two_d = sum_two_q;
		sum_one_d = sum_one_q;
		sum_cur_d = sum_cur_q;
		last_d    = last_q;
		prior_d   = prior_q;
		do_store  = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		case (mode_q)
			MODE_HUNT: begin
				if (byte_s1 == dpd_pkg::DLE_CODE) begin
					mode_d = MODE_WAIT_ID;
				end
			end
			MODE_WAIT_ID: begin
				if (byte_s1 == dpd_pkg::ETX_CODE) begin
					mode_d = MODE_HUNT;
				end else if (byte_s1 != dpd_pkg::DLE_CODE) begin
					mode_d   = MODE_DATA;
					do_store = 1'b1;
				end
			end
			MODE_DATA: begin
				if (byte_s1 == dpd_pkg::DLE_CODE) begin
					mode_d = MODE_ESC;
				end else begin
					do_store = 1'b1;
				end
			end
			MODE_ESC: begin
				if (byte_s1 == dpd_pkg::DLE_CODE) begin
					mode_d   = MODE_DATA;
					do_store = 1'b1;
				end else if (byte_s1 == dpd_pkg::ETX_CODE) begin
					mode_d                = MODE_HUNT;
					res_valid             = 1'b1;
					res.result_kind       = dpd_pkg::KIND_END;
					res.packet_length     = count_q;
					res.checksum_ok       = (count_q > dpd_pkg::LEN_W'(2)) &&
						(sum_two_q == tail);
				end else begin
					mode_d          = MODE_HUNT;
					res_valid       = 1'b1;
					res.result_kind = dpd_pkg::KIND_ABORT;
				end
			end
			default: begin
				mode_d = MODE_HUNT;
			end
		endcase

		if (do_store) begin
			res_valid = 1'b1;
			count_d   = base_count;
			sum_one_d = base_one;
			sum_cur_d = base_cur;
			last_d    = base_last;
			if (mode_q == MODE_WAIT_ID) begin
				sum_two_d = '0;
				prior_d   = '0;
			end
			if (base_count >= limit) begin
				mode_d          = MODE_HUNT;
				res.result_kind = dpd_pkg::KIND_TOO_LONG;
			end else begin
				sum_two_d         = base_one;
				sum_one_d         = base_cur;
				sum_cur_d         = base_cur + dpd_pkg::SUM_W'(byte_s1);
				prior_d           = base_last;
				last_d            = byte_s1;
				count_d           = base_count + dpd_pkg::LEN_W'(1);
				res.result_kind   = dpd_pkg::KIND_BYTE;
				res.data_byte     = byte_s1;
				res.byte_position = base_count[dpd_pkg::POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_HUNT;
			count_q   <= '0;
			sum_two_q <= '0;
			sum_one_q <= '0;
			sum_cur_q <= '0;
			last_q    <= '0;
			prior_q   <= '0;
		end else if (fire) begin
			mode_q    <= mode_d;
			count_q   <= count_d;
			sum_two_q <= sum_two_d;
			sum_one_q <= sum_one_d;
			sum_cur_q <= sum_cur_d;
			last_q    <= last_d;
			prior_q   <= prior_d;
		end
	end

endmodule

// ===== rtl/dpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// dpd_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module dpd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             res_valid,
	input  dpd_pkg::result_t res,
	output logic             can_take,
	dpd_result_if.source     result
);

	logic             valid_q;
	dpd_pkg::result_t res_q;

	assign can_take = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && fire && res_valid) begin
			res_q <= res;
		end
	end

	assign result.valid         = valid_q;
	assign result.result_kind   = res_q.result_kind;
	assign result.data_byte     = res_q.data_byte;
	assign result.byte_position = res_q.byte_position;
	assign result.packet_length = res_q.packet_length;
	assign result.checksum_ok   = res_q.checksum_ok;

endmodule

// ===== rtl/dle_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// dle_packet_deframer
// Recovers DLE/ETX byte-stuffed packets from a received byte stream.
// ----------------------------------------------------------------------------
// The rx channel carries one raw received byte per word. The result channel
// carries zero or one word per received byte: a stored byte with its position,
// a packet end with length and checksum flag, a too-long abort or a protocol
// error abort. Control bytes (start DLE, stuffing DLE, bytes while hunting)
// produce no result word.
// A byte passes an input register and then the framing logic, whose outcome
// lands in a result register, from which the receiver takes it. One byte is
// accepted every cycle for as long as the result register drains; the framing
// state machine and its single 16-bit adder handle a byte per cycle.
// When the receiver stalls, the result register holds its word and the input
// register holds the next byte; rx.ready drops only when both are occupied.
// The user must write max_length through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. Reset clears both registers' valid flags,
// returns the framer to hunting for a start DLE and sets max_length to 1024.
// ----------------------------------------------------------------------------
module dle_packet_deframer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dpd_pkg::LEN_W-1:0] cfg_wdata,
	dpd_byte_if.sink                  rx,
	dpd_result_if.source              result
);

	logic [dpd_pkg::LEN_W-1:0]  max_length_q;
	logic                       valid_s1;
	logic [dpd_pkg::BYTE_W-1:0] byte_s1;
	logic                       can_take;
	logic                       fire;
	logic                       res_valid;
	dpd_pkg::result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= dpd_pkg::LEN_W'(1024);
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	assign fire = valid_s1 && can_take;

	dpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (fire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dpd_frame_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.byte_s1    (byte_s1),
		.max_length (max_length_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	dpd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res),
		.can_take  (can_take),
		.result    (result)
	);

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Deframer regression
// Drives raw bytes into dle_packet_deframer and checks every result word
// against an in-bench model of the DLE/ETX framing. The byte mix runs from
// well-formed packets with correct and wrong checksums to broken frames and
// line noise, under several max_length settings, with random idle on both
// channels.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum logic [1:0] {
		MODE_HUNT    = 2'd0,
		MODE_WAIT_ID = 2'd1,
		MODE_DATA    = 2'd2,
		MODE_ESCAPED = 2'd3
	} frame_mode_t;

	localparam int END_CLEAN  = 0;
	localparam int END_BROKEN = 1;
	localparam int END_CUT    = 2;

	localparam int GAP_MAX = 18;
	localparam int SETTLE_CYCLES = 4;

	// Tracks the framing state and queues the result word that each received
	// byte should produce.
	class frame_scoreboard;
		dpd_pkg::result_t            expected_q[$];
		logic [dpd_pkg::LEN_W-1:0]   max_len;
		frame_mode_t                 mode;
		logic [dpd_pkg::LEN_W-1:0]   stored;
		logic [dpd_pkg::SUM_W-1:0]   sum_before_two;
		logic [dpd_pkg::SUM_W-1:0]   sum_before_one;
		logic [dpd_pkg::SUM_W-1:0]   sum_all;
		logic [dpd_pkg::BYTE_W-1:0]  last_b;
		logic [dpd_pkg::BYTE_W-1:0]  prior_b;
		int                          errors;
		int                          kind_seen[4];
		int                          good_sums;

		function new();
			max_len = dpd_pkg::LEN_W'(dpd_pkg::MAX_PACKET);
			mode = MODE_HUNT;
			stored = '0;
			sum_before_two = '0;
			sum_before_one = '0;
			sum_all = '0;
			last_b = '0;
			prior_b = '0;
			errors = 0;
			good_sums = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_result(dpd_pkg::kind_t k, logic [dpd_pkg::BYTE_W-1:0] d,
				logic [dpd_pkg::POS_W-1:0] p, logic [dpd_pkg::LEN_W-1:0] n, logic ok);
			dpd_pkg::result_t r;
			r.result_kind = k;
			r.data_byte = d;
			r.byte_position = p;
			r.packet_length = n;
			r.checksum_ok = ok;
			expected_q.push_back(r);
		endfunction

		function void store_byte(logic [dpd_pkg::BYTE_W-1:0] b);
			int lim;
			lim = (int'(max_len) < dpd_pkg::MAX_PACKET) ? int'(max_len) : dpd_pkg::MAX_PACKET;
			if (int'(stored) >= lim) begin
				mode = MODE_HUNT;
				push_result(dpd_pkg::KIND_TOO_LONG, '0, '0, '0, 1'b0);
				return;
			end
			sum_before_two = sum_before_one;
			sum_before_one = sum_all;
			sum_all = sum_all + dpd_pkg::SUM_W'(b);
			prior_b = last_b;
			last_b = b;
			push_result(dpd_pkg::KIND_BYTE, b, stored[dpd_pkg::POS_W-1:0], '0, 1'b0);
			stored = stored + dpd_pkg::LEN_W'(1);
		endfunction

		function void note_byte(logic [dpd_pkg::BYTE_W-1:0] b);
			logic ok;
			case (mode)
				MODE_HUNT: begin
					if (b == dpd_pkg::DLE_CODE) mode = MODE_WAIT_ID;
				end
				MODE_WAIT_ID: begin
					if (b == dpd_pkg::ETX_CODE) begin
						mode = MODE_HUNT;
					end else if (b != dpd_pkg::DLE_CODE) begin
						stored = '0;
						sum_before_two = '0;
						sum_before_one = '0;
						sum_all = '0;
						last_b = '0;
						prior_b = '0;
						mode = MODE_DATA;
						store_byte(b);
					end
				end
				MODE_DATA: begin
					if (b == dpd_pkg::DLE_CODE) mode = MODE_ESCAPED;
					else store_byte(b);
				end
				default: begin
					if (b == dpd_pkg::DLE_CODE) begin
						mode = MODE_DATA;
						store_byte(b);
					end else begin
						mode = MODE_HUNT;
						if (b == dpd_pkg::ETX_CODE) begin
							ok = (stored > dpd_pkg::LEN_W'(2)) &&
								(sum_before_two == {prior_b, last_b});
							push_result(dpd_pkg::KIND_END, '0, '0, stored, ok);
						end else begin
							push_result(dpd_pkg::KIND_ABORT, '0, '0, '0, 1'b0);
						end
					end
				end
			endcase
		endfunction

		function int field_diff(string name, int unsigned want, int unsigned got);
			if (want == got) return 0;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			return 1;
		endfunction

		function void check_result(dpd_pkg::result_t got);
			dpd_pkg::result_t want;
			int bad;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word, kind %0d data %0h pos %0d len %0d ok %0b",
					$time, got.result_kind, got.data_byte, got.byte_position,
					got.packet_length, got.checksum_ok);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			bad = 0;
			bad += field_diff("result_kind", want.result_kind, got.result_kind);
			bad += field_diff("data_byte", want.data_byte, got.data_byte);
			bad += field_diff("byte_position", want.byte_position, got.byte_position);
			bad += field_diff("packet_length", want.packet_length, got.packet_length);
			bad += field_diff("checksum_ok", want.checksum_ok, got.checksum_ok);
			errors += bad;
			kind_seen[int'(got.result_kind)]++;
			if (got.result_kind == dpd_pkg::KIND_END && got.checksum_ok) good_sums++;
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [dpd_pkg::LEN_W-1:0]  cfg_wdata;

	dpd_byte_if   rx_if();
	dpd_result_if res_if();

	dle_packet_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.result    (res_if)
	);

	frame_scoreboard sb = new();

	logic [dpd_pkg::BYTE_W-1:0] line_q[$];
	int  sent_count = 0;
	int  settings_used = 0;
	bit  tx_calm = 0;
	bit  rx_calm = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: a random stall before each word, with calm stretches.
	initial begin
		dpd_pkg::result_t got;
		int stall;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
			got.result_kind = dpd_pkg::kind_t'(res_if.result_kind);
			got.data_byte = res_if.data_byte;
			got.byte_position = res_if.byte_position;
			got.packet_length = res_if.packet_length;
			got.checksum_ok = res_if.checksum_ok;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	function automatic logic [dpd_pkg::BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 9))
			0, 1: return dpd_pkg::DLE_CODE;
			2: return dpd_pkg::ETX_CODE;
			default: return dpd_pkg::BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Valid stays high from one word to the next when no gap is drawn.
	task automatic send_byte(input logic [dpd_pkg::BYTE_W-1:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
		@(negedge clk);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (rx_if.ready !== 1'b1);
		sb.note_byte(b);
		sent_count++;
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_byte(line_q[i]);
		line_q.delete();
	endtask

	// Hold the input until every queued result is back and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [dpd_pkg::LEN_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.max_len = v;
		settings_used++;
	endtask

	task automatic queue_stuffed(input logic [dpd_pkg::BYTE_W-1:0] b);
		line_q.push_back(b);
		if (b == dpd_pkg::DLE_CODE) line_q.push_back(b);
	endtask

	// Frames n stored bytes; the last two are the checksum if sum_good and n >= 3.
	task automatic queue_packet(input int n, input bit sum_good, input int ending);
		logic [dpd_pkg::BYTE_W-1:0] body[$];
		logic [dpd_pkg::BYTE_W-1:0] id;
		logic [dpd_pkg::BYTE_W-1:0] junk;
		logic [dpd_pkg::SUM_W-1:0]  s;
		do id = rand_byte(); while (id == dpd_pkg::DLE_CODE || id == dpd_pkg::ETX_CODE);
		body.push_back(id);
		for (int i = 1; i < n; i++) body.push_back(rand_byte());
		if (sum_good && n >= 3) begin
			s = '0;
			for (int i = 0; i < n - 2; i++) s += dpd_pkg::SUM_W'(body[i]);
			body[n-2] = s[15:8];
			body[n-1] = s[7:0];
		end
		line_q.push_back(dpd_pkg::DLE_CODE);
		if ($urandom_range(0, 9) == 0) line_q.push_back(dpd_pkg::DLE_CODE);
		foreach (body[i]) queue_stuffed(body[i]);
		case (ending)
			END_CLEAN: begin
				line_q.push_back(dpd_pkg::DLE_CODE);
				line_q.push_back(dpd_pkg::ETX_CODE);
			end
			END_BROKEN: begin
				do junk = dpd_pkg::BYTE_W'($urandom_range(0, 255));
				while (junk == dpd_pkg::DLE_CODE || junk == dpd_pkg::ETX_CODE);
				line_q.push_back(dpd_pkg::DLE_CODE);
				line_q.push_back(junk);
			end
			default: ;
		endcase
	endtask

	task automatic run_phase(input int quota, input int lim);
		int goal;
		int r;
		int n;
		int ending;
		goal = sent_count + quota;
		while (sent_count < goal) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				repeat ($urandom_range(1, 4)) line_q.push_back(rand_byte());
			end else if (r < 14) begin
				line_q.push_back(dpd_pkg::DLE_CODE);
				if (r[0]) line_q.push_back(dpd_pkg::DLE_CODE);
				line_q.push_back(dpd_pkg::ETX_CODE);
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6) n = $urandom_range(1, 12);
				else if (r < 8) n = $urandom_range(1, 60);
				else n = (lim < 60) ? lim + $urandom_range(0, 1) : $urandom_range(13, 40);
				if (n < 1) n = 1;
				r = $urandom_range(0, 9);
				ending = (r < 8) ? END_CLEAN : (r == 8) ? END_BROKEN : END_CUT;
				queue_packet(n, $urandom_range(0, 3) != 0, ending);
			end
			send_line();
		end
	endtask

	initial begin
		int lim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Noise while hunting, DLE and ETX while waiting for the ID, a packet
		// with stuffed DLE, data ETX and a good checksum, a one-byte packet and
		// a DLE followed by a plain byte.
		line_q = '{8'h00, 8'hFF, dpd_pkg::DLE_CODE, dpd_pkg::DLE_CODE, dpd_pkg::ETX_CODE,
			dpd_pkg::DLE_CODE, 8'hFF, dpd_pkg::DLE_CODE, dpd_pkg::DLE_CODE,
			dpd_pkg::ETX_CODE, 8'h01, 8'h12,
			dpd_pkg::DLE_CODE, dpd_pkg::ETX_CODE,
			dpd_pkg::DLE_CODE, 8'h01, dpd_pkg::DLE_CODE, dpd_pkg::ETX_CODE,
			dpd_pkg::DLE_CODE, 8'h05, dpd_pkg::DLE_CODE, 8'h41};
		send_line();
		// A zero limit stops the packet at its ID byte; a limit of two at the third.
		write_limit(dpd_pkg::LEN_W'(0));
		line_q = '{dpd_pkg::DLE_CODE, 8'h20};
		send_line();
		write_limit(dpd_pkg::LEN_W'(2));
		line_q = '{dpd_pkg::DLE_CODE, 8'h20, 8'h21, 8'h22};
		send_line();
		write_limit(dpd_pkg::LEN_W'(1023));

		run_phase(100, 1023);
		for (int p = 0; p < 10; p++) begin
			case ($urandom_range(0, 3))
				0: lim = $urandom_range(0, 3);
				1: lim = $urandom_range(4, 40);
				2: lim = $urandom_range(41, 1023);
				default: lim = dpd_pkg::MAX_PACKET;
			endcase
			write_limit(dpd_pkg::LEN_W'(lim));
			run_phase(95, lim);
		end

		write_limit(dpd_pkg::LEN_W'(dpd_pkg::MAX_PACKET));
		run_phase(40, dpd_pkg::MAX_PACKET);

		settle();
		foreach (sb.expected_q[i]) begin
			$display("%0t: result never arrived, kind %0d", $time, sb.expected_q[i].result_kind);
			sb.errors++;
		end
		$display("Sent %0d bytes under %0d max_length settings.", sent_count, settings_used);
		$display("Results: %0d data bytes, %0d packet ends (%0d checksum ok), %0d too long, %0d aborts.",
			sb.kind_seen[dpd_pkg::KIND_BYTE], sb.kind_seen[dpd_pkg::KIND_END], sb.good_sums,
			sb.kind_seen[dpd_pkg::KIND_TOO_LONG], sb.kind_seen[dpd_pkg::KIND_ABORT]);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dpd_pkg.sv
rtl/dpd_if.sv
rtl/dpd_in_stage.sv
rtl/dpd_frame_fsm.sv
rtl/dpd_out_stage.sv
rtl/dle_packet_deframer.sv
verif/testbench.sv
